// ===== rtl/bbw_pkg.sv =====
// Shared constants, field widths and the rounding helper for the B-spline basis block.
`timescale 1ns / 1ps

package bbw_pkg;

    // Input coordinate width (Q0.16).
    localparam int IN_BITS = 16;

    // Result field widths.
    localparam int W0_BITS = 17;
    localparam int WN_BITS = 16;
    localparam int SLOPE_BITS = 17;
    localparam int CURVE_BITS = 18;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_BITS = 16;
    localparam int M_FIELD_BITS = W0_BITS + 3 * WN_BITS + 4 * SLOPE_BITS + 4 * CURVE_BITS;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    // Working width of the signed rounding helper.
    localparam int RND_BITS = 40;

    // Signed shift right by sh bits, rounded to nearest with halves away from zero.
    function automatic logic signed [RND_BITS-1:0] round_shift(
        input logic signed [RND_BITS-1:0] n,
        input int sh
    );
        logic [RND_BITS-1:0] mag;
        logic [RND_BITS-1:0] half;
        logic [RND_BITS-1:0] quo;
        mag = n[RND_BITS-1] ? RND_BITS'(-n) : RND_BITS'(n);
        half = (RND_BITS'(1) << sh) >> 1;
        quo = (mag + half) >> sh;
        return n[RND_BITS-1] ? -$signed(quo) : $signed(quo);
    endfunction

endpackage

// ===== rtl/bbw_powers.sv =====
// Two pipeline stages that form t squared and t cubed from the input coordinate.
`timescale 1ns / 1ps

module bbw_powers
    import bbw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_BITS-1:0]    in_x,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IN_BITS-1:0]    out_x,
    output logic [2*IN_BITS-1:0]  out_sq,
    output logic [3*IN_BITS-1:0]  out_cube
);

    logic                 v1_reg;
    logic [IN_BITS-1:0]   x1_reg;
    logic [2*IN_BITS-1:0] sq1_reg;
    logic                 v2_reg;
    logic [IN_BITS-1:0]   x2_reg;
    logic [2*IN_BITS-1:0] sq2_reg;
    logic [3*IN_BITS-1:0] cube2_reg;
    logic                 ready1;
    logic                 ready2;
    logic [2*IN_BITS-1:0] sq_next;
    logic [3*IN_BITS-1:0] cube_next;

    // Each stage takes a new item when it is empty or its item moves on.
    assign ready2 = !v2_reg || out_ready;
    assign ready1 = !v1_reg || ready2;
    assign in_ready = ready1;

    assign sq_next = (2 * IN_BITS)'(in_x) * (2 * IN_BITS)'(in_x);
    assign cube_next = (3 * IN_BITS)'(sq1_reg) * (3 * IN_BITS)'(x1_reg);

    // Stage one: square.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ready1) begin
            v1_reg <= in_valid;
        end
        if (ready1 && in_valid) begin
            x1_reg <= in_x;
            sq1_reg <= sq_next;
        end
    end

    // Stage two: cube.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ready2) begin
            v2_reg <= v1_reg;
        end
        if (ready2 && v1_reg) begin
            x2_reg <= x1_reg;
            sq2_reg <= sq1_reg;
            cube2_reg <= cube_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_x = x2_reg;
    assign out_sq = sq2_reg;
    assign out_cube = cube2_reg;

endmodule

// ===== rtl/bbw_terms.sv =====
// Pipeline stage that forms the polynomial numerators and their rounded shifts.
`timescale 1ns / 1ps

module bbw_terms
    import bbw_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int VW = FRAC_BITS + 3
)
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [IN_BITS-1:0]           in_x,
    input  logic [2*IN_BITS-1:0]         in_sq,
    input  logic [3*IN_BITS-1:0]         in_cube,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [VW-1:0]                out_half_w [4],
    output logic signed [SLOPE_BITS-1:0] out_slope [4],
    output logic signed [CURVE_BITS-1:0] out_curve [4]
);

    // Weight numerators are over 6 * 2^WS, slopes over 2^SS.
    localparam int WS = 3 * IN_BITS - FRAC_BITS;
    localparam int SS = 2 * IN_BITS + 1 - FRAC_BITS;
    localparam int CSH_L = (FRAC_BITS >= IN_BITS) ? FRAC_BITS - IN_BITS : 0;
    localparam int CSH_R = (FRAC_BITS < IN_BITS) ? IN_BITS - FRAC_BITS : 0;
    localparam int NW = 3 * IN_BITS + 5;
    localparam logic signed [NW-1:0] ONE3 = NW'(1) << (3 * IN_BITS);
    localparam logic signed [NW-1:0] WBIAS = NW'(3) << WS;
    localparam logic signed [RND_BITS-1:0] ONE2 = RND_BITS'(1) << (2 * IN_BITS);
    localparam logic signed [RND_BITS-1:0] ONE1 = RND_BITS'(1) << IN_BITS;

    logic                         v_reg;
    logic [VW-1:0]                half_w_reg [4];
    logic signed [SLOPE_BITS-1:0] slope_reg [4];
    logic signed [CURVE_BITS-1:0] curve_reg [4];
    logic [VW-1:0]                half_w_next [4];
    logic signed [SLOPE_BITS-1:0] slope_next [4];
    logic signed [CURVE_BITS-1:0] curve_next [4];
    logic signed [NW-1:0]         xw;
    logic signed [NW-1:0]         sqw;
    logic signed [NW-1:0]         cubew;
    logic signed [NW-1:0]         wnum [4];
    logic [NW-1:0]                wsum [4];
    logic signed [RND_BITS-1:0]   xs;
    logic signed [RND_BITS-1:0]   sqs;
    logic signed [RND_BITS-1:0]   snum [4];
    logic signed [RND_BITS-1:0]   cnum [4];
    logic signed [RND_BITS-1:0]   srnd [4];
    logic signed [RND_BITS-1:0]   crnd [4];

    assign in_ready = !v_reg || out_ready;

    // Numerators of all twelve terms, exact in integers.
    always_comb begin
        xw = NW'(in_x);
        sqw = NW'(in_sq);
        cubew = NW'(in_cube);
        wnum[0] = ONE3 - ((3 * xw) <<< (2 * IN_BITS)) + ((3 * sqw) <<< IN_BITS) - cubew;
        wnum[1] = (3 * cubew) - ((6 * sqw) <<< IN_BITS) + (ONE3 <<< 2);
        wnum[2] = ONE3 + ((3 * xw) <<< (2 * IN_BITS)) + ((3 * sqw) <<< IN_BITS) - (3 * cubew);
        wnum[3] = cubew;

        xs = RND_BITS'(in_x);
        sqs = RND_BITS'(in_sq);
        snum[0] = ((2 * xs) <<< IN_BITS) - ONE2 - sqs;
        snum[1] = (3 * sqs) - ((4 * xs) <<< IN_BITS);
        snum[2] = ONE2 + ((2 * xs) <<< IN_BITS) - (3 * sqs);
        snum[3] = sqs;

        cnum[0] = ONE1 - xs;
        cnum[1] = (3 * xs) - (ONE1 <<< 1);
        cnum[2] = ONE1 - (3 * xs);
        cnum[3] = xs;

        // Weights are never negative, so rounding is a bias and a plain shift.
        // One extra bit of shift leaves a division by three for the next stages.
        for (int i = 0; i < 4; i++) begin
            wsum[i] = NW'(wnum[i] + WBIAS);
            half_w_next[i] = VW'(wsum[i] >> (WS + 1));
            srnd[i] = round_shift(snum[i], SS);
            crnd[i] = round_shift(cnum[i], CSH_R) <<< CSH_L;
            slope_next[i] = srnd[i][SLOPE_BITS-1:0];
            curve_next[i] = crnd[i][CURVE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            half_w_reg <= half_w_next;
            slope_reg <= slope_next;
            curve_reg <= curve_next;
        end
    end

    assign out_valid = v_reg;
    assign out_half_w = half_w_reg;
    assign out_slope = slope_reg;
    assign out_curve = curve_reg;

endmodule

// ===== rtl/bbw_div3.sv =====
// Two pipeline stages that divide the weights by three through a reciprocal multiply.
`timescale 1ns / 1ps

module bbw_div3
    import bbw_pkg::*;
#(
    parameter int VW = 19
)
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [VW-1:0]                in_half_w [4],
    input  logic signed [SLOPE_BITS-1:0] in_slope [4],
    input  logic signed [CURVE_BITS-1:0] in_curve [4],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [W0_BITS-1:0]           out_weight_0,
    output logic [WN_BITS-1:0]           out_weight_n [3],
    output logic signed [SLOPE_BITS-1:0] out_slope [4],
    output logic signed [CURVE_BITS-1:0] out_curve [4]
);

    // floor(v / 3) = (v * MAGIC) >> K, exact for every VW-bit v.
    localparam int K = VW + 2;
    localparam int PW = 2 * VW + 1;
    localparam logic [VW:0] MAGIC = (VW + 1)'(((64'd1 << K) + 64'd2) / 64'd3);

    logic                         v4_reg;
    logic [PW-1:0]                prod_reg [4];
    logic signed [SLOPE_BITS-1:0] slope4_reg [4];
    logic signed [CURVE_BITS-1:0] curve4_reg [4];
    logic                         v5_reg;
    logic [W0_BITS-1:0]           weight0_reg;
    logic [WN_BITS-1:0]           weightn_reg [3];
    logic signed [SLOPE_BITS-1:0] slope5_reg [4];
    logic signed [CURVE_BITS-1:0] curve5_reg [4];
    logic                         ready4;
    logic                         ready5;
    logic [PW-1:0]                prod_next [4];
    logic [PW-1:0]                quo [4];

    assign ready5 = !v5_reg || out_ready;
    assign ready4 = !v4_reg || ready5;
    assign in_ready = ready4;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod_next[i] = PW'(in_half_w[i]) * PW'(MAGIC);
            quo[i] = prod_reg[i] >> K;
        end
    end

    // Stage four: reciprocal products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (ready4) begin
            v4_reg <= in_valid;
        end
        if (ready4 && in_valid) begin
            prod_reg <= prod_next;
            slope4_reg <= in_slope;
            curve4_reg <= in_curve;
        end
    end

    // Stage five: quotients, trimmed to the result fields; this is the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (ready5) begin
            v5_reg <= v4_reg;
        end
        if (ready5 && v4_reg) begin
            weight0_reg <= quo[0][W0_BITS-1:0];
            for (int i = 0; i < 3; i++) begin
                weightn_reg[i] <= quo[i+1][WN_BITS-1:0];
            end
            slope5_reg <= slope4_reg;
            curve5_reg <= curve4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_weight_0 = weight0_reg;
    assign out_weight_n = weightn_reg;
    assign out_slope = slope5_reg;
    assign out_curve = curve5_reg;

endmodule

// ===== rtl/cubic_bspline_basis_weights.sv =====
// An accepted item reaches the master side after passing through all five register stages.
// Throughput: one item per cycle while the output is not stalled; each of the five register stages holds one item.
// The critical paths are the 32 by 16 cube multiply and the reciprocal multiplies.
// Reset (aresetn low, synchronous) empties every stage; no clearing pass is needed.
// A stalled output holds its item while the earlier stages keep filling.
`timescale 1ns / 1ps

module cubic_bspline_basis_weights
    import bbw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata from bit 0: frac_t[15:0]
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata from bit 0: weight_0[16:0], weight_1[32:17], weight_2[48:33], weight_3[64:49],
    // slope_0[81:65], slope_1[98:82], slope_2[115:99], slope_3[132:116],
    // curve_0[150:133], curve_1[168:151], curve_2[186:169], curve_3[204:187], zeros
    output logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    localparam int VW = FRAC_BITS + 3;

    logic                         pw_valid;
    logic                         pw_ready;
    logic [IN_BITS-1:0]           pw_x;
    logic [2*IN_BITS-1:0]         pw_sq;
    logic [3*IN_BITS-1:0]         pw_cube;
    logic                         tm_valid;
    logic                         tm_ready;
    logic [VW-1:0]                tm_half_w [4];
    logic signed [SLOPE_BITS-1:0] tm_slope [4];
    logic signed [CURVE_BITS-1:0] tm_curve [4];
    logic [W0_BITS-1:0]           res_weight_0;
    logic [WN_BITS-1:0]           res_weight_n [3];
    logic signed [SLOPE_BITS-1:0] res_slope [4];
    logic signed [CURVE_BITS-1:0] res_curve [4];

    // Powers of t.
    bbw_powers u_powers (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_x      (s_axis_tdata[IN_BITS-1:0]),
        .out_valid (pw_valid),
        .out_ready (pw_ready),
        .out_x     (pw_x),
        .out_sq    (pw_sq),
        .out_cube  (pw_cube)
    );

    // Numerators and rounding.
    bbw_terms #(
        .FRAC_BITS (FRAC_BITS),
        .VW        (VW)
    ) u_terms (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (pw_valid),
        .in_ready   (pw_ready),
        .in_x       (pw_x),
        .in_sq      (pw_sq),
        .in_cube    (pw_cube),
        .out_valid  (tm_valid),
        .out_ready  (tm_ready),
        .out_half_w (tm_half_w),
        .out_slope  (tm_slope),
        .out_curve  (tm_curve)
    );

    // Division of the weights by three and the output register.
    bbw_div3 #(
        .VW (VW)
    ) u_div3 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (tm_valid),
        .in_ready     (tm_ready),
        .in_half_w    (tm_half_w),
        .in_slope     (tm_slope),
        .in_curve     (tm_curve),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_weight_0 (res_weight_0),
        .out_weight_n (res_weight_n),
        .out_slope    (res_slope),
        .out_curve    (res_curve)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = M_TDATA_BITS'({
        res_curve[3], res_curve[2], res_curve[1], res_curve[0],
        res_slope[3], res_slope[2], res_slope[1], res_slope[0],
        res_weight_n[2], res_weight_n[1], res_weight_n[0], res_weight_0
    });

endmodule

// ===== rtl/bbw_checker.sv =====
// Port-level checks for the B-spline basis block and the bind that attaches them.
`timescale 1ns / 1ps

module bbw_checker
    import bbw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [S_TDATA_BITS-1:0] s_axis_tdata,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    localparam logic [CURVE_BITS-1:0] ONE_CODE = CURVE_BITS'(64'd1 << FRAC_BITS);

    logic [CURVE_BITS-1:0] curve_sum;

    assign curve_sum = m_axis_tdata[150:133] + m_axis_tdata[204:187];

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // With the output free, every stage can move, so the input is ready.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

    // A stalled result is held unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Padding above the last field stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_BITS-1:M_FIELD_BITS] == '0)
        else $error("padding bits set");

    // Second derivatives of the outer weights, 1-t and t, sum to one when exact.
    a_curve_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (FRAC_BITS >= IN_BITS) |-> curve_sum == ONE_CODE)
        else $error("outer curvatures do not sum to one");

endmodule

bind cubic_bspline_basis_weights bbw_checker #(.FRAC_BITS(FRAC_BITS)) u_bbw_checker (.*);
